FILE: rtl/core/utv_pkg.sv
// Common types, codes and lead byte decode for the utf-8 text validator
package utv_pkg;

  // result cause codes
  localparam logic [2:0] CAUSE_OK        = 3'd0;
  localparam logic [2:0] CAUSE_ALL_ASCII = 3'd1;
  localparam logic [2:0] CAUSE_BAD_LEAD  = 3'd2;
  localparam logic [2:0] CAUSE_BAD_CONT  = 3'd3;
  localparam logic [2:0] CAUSE_TRUNCATED = 3'd4;

  // latched error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_LEAD = 2'd1;
  localparam logic [1:0] ERR_CONT = 2'd2;

  // one input item held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic       is_utf8;
    logic [2:0] cause;
  } result_t;

  // continuation bytes that follow a lead byte at or above 0xC0
  function automatic logic [2:0] follow_count(input logic [7:0] b);
    logic [2:0] cnt;
    if (b inside {[8'hFC:8'hFD]}) begin
      cnt = 3'd5;
    end else if (b >= 8'hF8) begin
      cnt = 3'd4;
    end else if (b >= 8'hF0) begin
      cnt = 3'd3;
    end else if (b >= 8'hE0) begin
      cnt = 3'd2;
    end else begin
      cnt = 3'd1;
    end
    return cnt;
  endfunction

endpackage

FILE: rtl/core/utv_in_reg.sv
// Input register stage of the utf-8 text validator
module utv_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  utv_pkg::in_item_t in_item,
  output logic              hold_valid,
  output utv_pkg::in_item_t hold_item,
  input  logic              hold_take
);

  logic              valid_r;
  logic              valid_nxt;
  utv_pkg::in_item_t item_r;

  // accept when empty or when the held item leaves this cycle
  assign in_ready = !valid_r || hold_take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (hold_take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign hold_valid = valid_r;
  assign hold_item  = item_r;

endmodule

FILE: rtl/core/utv_check.sv
// Per-text validation state and per-byte check logic
module utv_check (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  utv_pkg::in_item_t item,
  output utv_pkg::result_t  result
);

  logic [2:0] pending_r;
  logic [2:0] pending_nxt;
  logic       ascii_r;
  logic       ascii_nxt;
  logic [1:0] error_r;
  logic [1:0] error_nxt;
  logic [2:0] pend_upd;
  logic       ascii_upd;
  logic [1:0] error_upd;
  logic [7:0] b;
  logic       is_lead;

  assign b = item.data_byte;

  // lead byte class of the held byte
  utv_top_doc_placeholder u_lead (
    .data_byte     (b),
    .is_lead_range (is_lead)
  );

  // state after taking this byte
  always_comb begin
    pend_upd  = pending_r;
    ascii_upd = ascii_r;
    error_upd = error_r;
    if (error_r == utv_pkg::ERR_NONE) begin
      if (b[7]) begin
        ascii_upd = 1'b0;
      end
      if (pending_r == 3'd0) begin
        if (b[7]) begin
          if (!is_lead) begin
            error_upd = utv_pkg::ERR_LEAD;
          end else begin
            pend_upd = utv_pkg::follow_count(b);
          end
        end
      end else begin
        if (b[7:6] != 2'b10) begin
          error_upd = utv_pkg::ERR_CONT;
        end else begin
          pend_upd = pending_r - 3'd1;
        end
      end
    end
  end

  // cause by priority: latched error, truncation, all ascii
  always_comb begin
    if (error_upd == utv_pkg::ERR_LEAD) begin
      result.cause = utv_pkg::CAUSE_BAD_LEAD;
    end else if (error_upd == utv_pkg::ERR_CONT) begin
      result.cause = utv_pkg::CAUSE_BAD_CONT;
    end else if (pend_upd != 3'd0) begin
      result.cause = utv_pkg::CAUSE_TRUNCATED;
    end else if (ascii_upd) begin
      result.cause = utv_pkg::CAUSE_ALL_ASCII;
    end else begin
      result.cause = utv_pkg::CAUSE_OK;
    end
    result.is_utf8 = (result.cause == utv_pkg::CAUSE_OK);
  end

  // last byte returns the state to its start values
  always_comb begin
    pending_nxt = pending_r;
    ascii_nxt   = ascii_r;
    error_nxt   = error_r;
    if (take) begin
      if (item.last_byte) begin
        pending_nxt = 3'd0;
        ascii_nxt   = 1'b1;
        error_nxt   = utv_pkg::ERR_NONE;
      end else begin
        pending_nxt = pend_upd;
        ascii_nxt   = ascii_upd;
        error_nxt   = error_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 3'd0;
      ascii_r   <= 1'b1;
      error_r   <= utv_pkg::ERR_NONE;
    end else begin
      pending_r <= pending_nxt;
      ascii_r   <= ascii_nxt;
      error_r   <= error_nxt;
    end
  end

endmodule

FILE: rtl/core/utv_out_reg.sv
// Result register of the utf-8 text validator
module utv_out_reg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  utv_pkg::result_t result,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output utv_pkg::result_t out_result
);

  logic             valid_r;
  logic             valid_nxt;
  utv_pkg::result_t result_r;

  // room for a new result when empty or being drained now
  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

FILE: rtl/core/utv_top_doc_placeholder.sv
// Byte class decode of one held item, used to qualify lead bytes in the check logic
module utv_top_doc_placeholder (
  input  logic [7:0] data_byte,
  output logic       is_lead_range
);

  // bytes 0xc0 and above open a multi-byte sequence
  assign is_lead_range = data_byte[7] & data_byte[6];

endmodule

FILE: rtl/core/utf8_text_validator.sv
// Top level of the utf-8 text validator
// Checks a text one byte per item and, on the byte marked last, gives one result item
// saying whether the text is non-ascii utf-8 and why not. A byte is accepted every
// clock unless a held result stalls the output; the byte passes an input register, the
// check logic and the result register. Throughput is one item per cycle when the output
// does not stall; bytes that are not last give no result and never wait on the output
// side unless a result is held.
module utf8_text_validator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] is_utf8, [3:1] cause, [7:4] zero
);

  utv_pkg::in_item_t in_item;
  utv_pkg::in_item_t hold_item;
  utv_pkg::result_t  result;
  utv_pkg::result_t  out_result;
  logic              hold_valid;
  logic              hold_take;
  logic              out_free;
  logic              out_load;

  assign in_item.data_byte = in_tdata;
  assign in_item.last_byte = in_tlast;

  // held item moves on when the result register can take it
  assign hold_take = hold_valid && out_free;
  assign out_load  = hold_take && hold_item.last_byte;

  utv_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .hold_take  (hold_take)
  );

  utv_check u_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (hold_take),
    .item   (hold_item),
    .result (result)
  );

  utv_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (out_load),
    .result     (result),
    .free       (out_free),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = {4'd0, out_result.cause, out_result.is_utf8};

endmodule
